// ===== rtl/fra_pkg.sv =====
package fra_pkg;

   localparam int FRAME_SLOTS = 16;
   localparam int OFFSET_BITS = 24;

   localparam int SLOT_W      = $clog2(FRAME_SLOTS);
   localparam int OFS_W       = OFFSET_BITS + 1;
   localparam int LEN_W       = 25;
   localparam int SIZE_W      = 24;
   localparam int ADDR_W      = 32;
   localparam int ALU_W       = 32;
   localparam int CSR_DATA_W  = 32;
   localparam int ALIGN_LOW   = 255;
   localparam int ALIGN_SHIFT = 8;

   localparam logic [OFS_W-1:0]  OFS_MAX = {OFS_W{1'b1}};
   localparam logic [LEN_W:0]    LEN_MAX = (LEN_W + 1)'(64'd1 << OFFSET_BITS);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(FRAME_SLOTS - 1);

   localparam logic [1:0] OP_CREATE = 2'd0;
   localparam logic [1:0] OP_FREE   = 2'd1;
   localparam logic [1:0] OP_PEEK   = 2'd2;

   localparam logic CSR_BASE_ADDRESS  = 1'b0;
   localparam logic CSR_BUFFER_LENGTH = 1'b1;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_RING_OVF   = 2'd1,
      ST_FIFO_FULL  = 2'd2,
      ST_FIFO_EMPTY = 2'd3
   } status_type;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] slot;
      logic [OFS_W-1:0]  ofs;
      logic [LEN_W-1:0]  len;
   } desc_wr_type;

   typedef struct packed {
      logic              init;
      logic [OFS_W-1:0]  blen;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      status_type        status;
      logic [ADDR_W-1:0] addr;
      logic [LEN_W-1:0]  len;
      logic [3:0]        slot;
   } result_type;

   // slot index as reported on the result, low four bits
   function automatic logic [3:0] slot_out(input logic [SLOT_W-1:0] s);
      logic [SLOT_W+3:0] ext;
      ext = {4'b0, s};
      return ext[3:0];
   endfunction

endpackage

// ===== rtl/fra_alu.sv =====
module fra_alu
   import fra_pkg::*;
(
   input  alu_op_type       op,
   input  logic [ALU_W-1:0] a,
   input  logic [ALU_W-1:0] b,
   output logic [ALU_W:0]   res
);

   // top bit is carry on add and borrow on subtract
   always_comb begin
      unique case (op)
         ALU_ADD: res = {1'b0, a} + {1'b0, b};
         ALU_SUB: res = {1'b0, a} - {1'b0, b};
         default: res = '0;
      endcase
   end

endmodule

// ===== rtl/fra_desc.sv =====
module fra_desc
   import fra_pkg::*;
(
   input  logic              clock,
   input  desc_wr_type       wr,
   input  logic [SLOT_W-1:0] rd_slot,
   output logic [OFS_W-1:0]  rd_ofs,
   output logic [LEN_W-1:0]  rd_len
);

   logic [OFS_W-1:0] ofs_ff [FRAME_SLOTS];
   logic [LEN_W-1:0] len_ff [FRAME_SLOTS];

   // only slots between head and tail are ever read, all written by a create
   always_ff @(posedge clock) begin
      if (wr.en) begin
         ofs_ff[wr.slot] <= wr.ofs;
         len_ff[wr.slot] <= wr.len;
      end
   end

   assign rd_ofs = ofs_ff[rd_slot];
   assign rd_len = len_ff[rd_slot];

endmodule

// ===== rtl/fra_ctrl.sv =====
module fra_ctrl
   import fra_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_op,
   input  logic [SIZE_W-1:0] req_size,
   input  cfg_type           cfg,
   input  logic [ADDR_W-1:0] base,
   input  logic [OFS_W-1:0]  blen,
   output result_type        done,
   input  logic              done_ready,
   output desc_wr_type       desc_wr,
   output logic [SLOT_W-1:0] desc_rd_slot,
   input  logic [OFS_W-1:0]  desc_rd_ofs,
   input  logic [LEN_W-1:0]  desc_rd_len,
   output alu_op_type        alu_op,
   output logic [ALU_W-1:0]  alu_a,
   output logic [ALU_W-1:0]  alu_b,
   input  logic [ALU_W:0]    alu_res
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_ROUND,
      S_SPACE,
      S_END_SUM,
      S_WRAP,
      S_FRAG,
      S_FRAG_SUM,
      S_FRAG_CMP,
      S_FREE_SUB,
      S_COMMIT,
      S_FREE_ADD,
      S_BEGIN_ADD,
      S_TAIL_SUM,
      S_TAIL_CMP,
      S_TAIL_RET,
      S_ADDR
   } state_type;

   state_type         state_ff, state_in;
   logic              done_ff, done_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [LEN_W-1:0]  real_ff, real_in;
   logic [OFS_W-1:0]  ofs_ff, ofs_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   status_type        status_ff, status_in;
   logic [ALU_W-1:0]  tmp_ff, tmp_in;
   logic [OFS_W-1:0]  frag_ff, frag_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [OFS_W-1:0]  begin_ff, begin_in;
   logic [OFS_W-1:0]  end_ff, end_in;
   logic [OFS_W-1:0]  free_ff, free_in;
   logic [OFS_W-1:0]  tail_bytes_ff, tail_bytes_in;
   logic [SLOT_W-1:0] head_ff, head_in;
   logic [SLOT_W-1:0] tail_slot_ff, tail_slot_in;

   logic [SLOT_W-1:0] next_tail;
   logic [SLOT_W-1:0] next_head;
   logic              borrow;
   logic              sum_over;

   assign next_tail = (tail_slot_ff == SLOT_LAST) ? '0 : tail_slot_ff + 1'b1;
   assign next_head = (head_ff == SLOT_LAST) ? '0 : head_ff + 1'b1;
   assign borrow    = alu_res[ALU_W];
   // free count saturation on add
   assign sum_over  = |alu_res[ALU_W:OFS_W];

   assign req_ready    = (state_ff == S_IDLE) && !done_ff;
   assign desc_rd_slot = head_ff;

   assign done.valid  = done_ff;
   assign done.status = status_ff;
   assign done.addr   = addr_ff;
   assign done.len    = len_ff;
   assign done.slot   = slot_out(slot_ff);

   always_comb begin
      state_in      = state_ff;
      done_in       = done_ff;
      size_in       = size_ff;
      real_in       = real_ff;
      ofs_in        = ofs_ff;
      len_in        = len_ff;
      slot_in       = slot_ff;
      status_in     = status_ff;
      tmp_in        = tmp_ff;
      frag_in       = frag_ff;
      addr_in       = addr_ff;
      begin_in      = begin_ff;
      end_in        = end_ff;
      free_in       = free_ff;
      tail_bytes_in = tail_bytes_ff;
      head_in       = head_ff;
      tail_slot_in  = tail_slot_ff;
      alu_op        = ALU_ADD;
      alu_a         = '0;
      alu_b         = '0;
      desc_wr.en    = 1'b0;
      desc_wr.slot  = tail_slot_ff;
      desc_wr.ofs   = ofs_ff;
      desc_wr.len   = real_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (done_ff && done_ready) begin
               done_in = 1'b0;
            end
            if (req_valid && req_ready) begin
               size_in = req_size;
               if (req_op == OP_CREATE) begin
                  state_in = S_ROUND;
               end else if (head_ff == tail_slot_ff) begin
                  status_in = ST_FIFO_EMPTY;
                  ofs_in    = '0;
                  len_in    = '0;
                  slot_in   = head_ff;
                  state_in  = S_ADDR;
               end else begin
                  status_in = ST_OK;
                  ofs_in    = desc_rd_ofs;
                  len_in    = desc_rd_len;
                  slot_in   = head_ff;
                  state_in  = (req_op == OP_FREE) ? S_FREE_ADD : S_ADDR;
               end
            end
         end
         S_ROUND: begin
            alu_a    = ALU_W'(size_ff);
            alu_b    = ALU_W'(ALIGN_LOW);
            real_in  = {alu_res[LEN_W-1:ALIGN_SHIFT], {ALIGN_SHIFT{1'b0}}};
            len_in   = real_in;
            slot_in  = tail_slot_ff;
            state_in = S_SPACE;
         end
         S_SPACE: begin
            alu_op = ALU_SUB;
            alu_a  = ALU_W'(free_ff);
            alu_b  = ALU_W'(real_ff);
            if (borrow) begin
               status_in = ST_RING_OVF;
               ofs_in    = '0;
               state_in  = S_ADDR;
            end else if (next_tail == head_ff) begin
               status_in = ST_FIFO_FULL;
               ofs_in    = '0;
               state_in  = S_ADDR;
            end else begin
               status_in = ST_OK;
               state_in  = S_END_SUM;
            end
         end
         S_END_SUM: begin
            alu_a    = ALU_W'(end_ff);
            alu_b    = ALU_W'(real_ff);
            tmp_in   = alu_res[ALU_W-1:0];
            state_in = S_WRAP;
         end
         S_WRAP: begin
            alu_op = ALU_SUB;
            alu_a  = ALU_W'(blen);
            alu_b  = tmp_ff;
            if (borrow) begin
               state_in = S_FRAG;
            end else begin
               ofs_in   = end_ff;
               state_in = S_FREE_SUB;
            end
         end
         S_FRAG: begin
            alu_op  = ALU_SUB;
            alu_a   = ALU_W'(blen);
            alu_b   = ALU_W'(end_ff);
            frag_in = borrow ? '0 : alu_res[OFS_W-1:0];
            ofs_in  = '0;
            if (tail_bytes_ff == '0) begin
               state_in = S_FRAG_SUM;
            end else begin
               // a tail is already pending: it is replaced, only the frame is taken from the free count
               tail_bytes_in = frag_in;
               state_in      = S_FREE_SUB;
            end
         end
         S_FRAG_SUM: begin
            alu_a    = ALU_W'(frag_ff);
            alu_b    = ALU_W'(real_ff);
            tmp_in   = alu_res[ALU_W-1:0];
            state_in = S_FRAG_CMP;
         end
         S_FRAG_CMP: begin
            alu_op = ALU_SUB;
            alu_a  = ALU_W'(free_ff);
            alu_b  = tmp_ff;
            if (borrow) begin
               status_in = ST_RING_OVF;
               state_in  = S_ADDR;
            end else begin
               // fragment and frame taken from the free count together
               free_in       = alu_res[OFS_W-1:0];
               tail_bytes_in = frag_ff;
               state_in      = S_COMMIT;
            end
         end
         S_FREE_SUB: begin
            alu_op   = ALU_SUB;
            alu_a    = ALU_W'(free_ff);
            alu_b    = ALU_W'(real_ff);
            free_in  = alu_res[OFS_W-1:0];
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            alu_a        = ALU_W'(ofs_ff);
            alu_b        = ALU_W'(real_ff);
            end_in       = alu_res[OFS_W-1:0];
            desc_wr.en   = 1'b1;
            tail_slot_in = next_tail;
            state_in     = S_ADDR;
         end
         S_FREE_ADD: begin
            alu_a    = ALU_W'(free_ff);
            alu_b    = ALU_W'(len_ff);
            free_in  = sum_over ? OFS_MAX : alu_res[OFS_W-1:0];
            head_in  = next_head;
            state_in = S_BEGIN_ADD;
         end
         S_BEGIN_ADD: begin
            alu_a    = ALU_W'(begin_ff);
            alu_b    = ALU_W'(len_ff);
            begin_in = alu_res[OFS_W-1:0];
            state_in = S_TAIL_SUM;
         end
         S_TAIL_SUM: begin
            alu_a    = ALU_W'(begin_ff);
            alu_b    = ALU_W'(tail_bytes_ff);
            tmp_in   = alu_res[ALU_W-1:0];
            state_in = S_TAIL_CMP;
         end
         S_TAIL_CMP: begin
            alu_op   = ALU_SUB;
            alu_a    = tmp_ff;
            alu_b    = ALU_W'(blen);
            state_in = borrow ? S_ADDR : S_TAIL_RET;
         end
         S_TAIL_RET: begin
            // begin pointer reached the skipped tail, return it
            alu_a         = ALU_W'(free_ff);
            alu_b         = ALU_W'(tail_bytes_ff);
            free_in       = sum_over ? OFS_MAX : alu_res[OFS_W-1:0];
            tail_bytes_in = '0;
            begin_in      = '0;
            state_in      = S_ADDR;
         end
         S_ADDR: begin
            alu_a    = base;
            alu_b    = ALU_W'(ofs_ff);
            addr_in  = alu_res[ADDR_W-1:0];
            done_in  = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      if (cfg.init) begin
         begin_in      = '0;
         end_in        = '0;
         free_in       = cfg.blen;
         tail_bytes_in = '0;
         head_in       = '0;
         tail_slot_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         done_ff       <= 1'b0;
         begin_ff      <= '0;
         end_ff        <= '0;
         free_ff       <= '0;
         tail_bytes_ff <= '0;
         head_ff       <= '0;
         tail_slot_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         done_ff       <= done_in;
         begin_ff      <= begin_in;
         end_ff        <= end_in;
         free_ff       <= free_in;
         tail_bytes_ff <= tail_bytes_in;
         head_ff       <= head_in;
         tail_slot_ff  <= tail_slot_in;
      end
      size_ff   <= size_in;
      real_ff   <= real_in;
      ofs_ff    <= ofs_in;
      len_ff    <= len_in;
      slot_ff   <= slot_in;
      status_ff <= status_in;
      tmp_ff    <= tmp_in;
      frag_ff   <= frag_in;
      addr_ff   <= addr_in;
   end

   a_head_moves_on_free: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && head_ff != $past(head_ff))
         |-> ($past(state_ff) == S_FREE_ADD || $past(cfg.init)))
      else $error("head slot moved outside a free");

   a_tail_moves_on_commit: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && tail_slot_ff != $past(tail_slot_ff))
         |-> ($past(state_ff) == S_COMMIT || $past(cfg.init)))
      else $error("tail slot moved outside a create");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (done_ff && !done_ready) |=> (done_ff && state_ff == S_IDLE && $stable(addr_ff)))
      else $error("pending result lost before hand-off");

   a_commit_has_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COMMIT) |-> (next_tail != head_ff && status_ff == ST_OK))
      else $error("descriptor written into a full fifo");

endmodule

// ===== rtl/frame_ring_allocator_top.sv =====
// channel   direction  handshake                tdata / tuser
// req       in         req_tvalid / req_tready  tdata frame_size, tuser op
// rsp       out        rsp_tvalid / rsp_tready  tdata address, length, slot; tuser status
// csr       in         csr_valid / csr_ready    csr_index, csr_data
//
// one 32-bit adder/subtractor is stepped by the sequencer, one operation per cycle
// accept to next accept: peek or empty free/peek only forms the address; free adds the
// length to free count and begin pointer, returning a reached tail; create rounds, checks
// space and fifo, sums the end, checks wrap, on a wrap sizes the fragment, then commits
// reset clears pointers, counters and control state; data and result registers and descriptor storage are not cleared
// a stalled rsp_tready holds the result and then holds the sequencer in idle
module frame_ring_allocator_top
   import fra_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,   // [23:0] frame_size
   input  logic [1:0]            req_tuser,   // [1:0] op
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [63:0]           rsp_tdata,   // [31:0] frame_address, [56:32] frame_length,
                                              // [60:57] frame_slot, [63:61] zero
   output logic [1:0]            rsp_tuser,   // [1:0] status
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [ADDR_W-1:0] base_ff, base_in;
   logic [OFS_W-1:0]  blen_ff, blen_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff, rsp_in;

   cfg_type           cfg;
   result_type        done;
   logic              done_ready;
   desc_wr_type       desc_wr;
   logic [SLOT_W-1:0] desc_rd_slot;
   logic [OFS_W-1:0]  desc_rd_ofs;
   logic [LEN_W-1:0]  desc_rd_len;
   alu_op_type        alu_op;
   logic [ALU_W-1:0]  alu_a;
   logic [ALU_W-1:0]  alu_b;
   logic [ALU_W:0]    alu_res;
   logic              csr_write;
   logic [LEN_W:0]    len_wr;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign len_wr    = {1'b0, csr_data[LEN_W-1:0]};

   always_comb begin
      base_in = base_ff;
      blen_in = blen_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_BASE_ADDRESS:  base_in = csr_data[ADDR_W-1:0];
            CSR_BUFFER_LENGTH: blen_in = (len_wr > LEN_MAX) ? OFS_W'(LEN_MAX) : OFS_W'(len_wr);
            default:           base_in = base_ff;
         endcase
      end
   end

   assign cfg.init = csr_write;
   assign cfg.blen = blen_in;

   // output register frees the sequencer as soon as the result is handed over
   assign done_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (done.valid && done_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         blen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         blen_ff      <= blen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {3'b000, rsp_ff.slot, rsp_ff.len, rsp_ff.addr};

   fra_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_op       (req_tuser),
      .req_size     (req_tdata),
      .cfg          (cfg),
      .base         (base_ff),
      .blen         (blen_ff),
      .done         (done),
      .done_ready   (done_ready),
      .desc_wr      (desc_wr),
      .desc_rd_slot (desc_rd_slot),
      .desc_rd_ofs  (desc_rd_ofs),
      .desc_rd_len  (desc_rd_len),
      .alu_op       (alu_op),
      .alu_a        (alu_a),
      .alu_b        (alu_b),
      .alu_res      (alu_res)
   );

   fra_desc u_desc (
      .clock   (clock),
      .wr      (desc_wr),
      .rd_slot (desc_rd_slot),
      .rd_ofs  (desc_rd_ofs),
      .rd_len  (desc_rd_len)
   );

   fra_alu u_alu (
      .op  (alu_op),
      .a   (alu_a),
      .b   (alu_b),
      .res (alu_res)
   );

endmodule
